// ----- rtl/avc_ts_pkg.sv -----
// Shared types and constants for the AVC tag to start-code stream unit.
// Used by the input stage, the parser, the emitter and the top level.
// No dependencies.
package avc_ts_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_PPS_COUNT = 3'd1,
        PH_LENGTH    = 3'd2,
        PH_DATA      = 3'd3,
        PH_IDLE      = 3'd4
    } phase_t;

    // Unit kinds carried on the output.
    localparam logic [1:0] KIND_SPS   = 2'd0;
    localparam logic [1:0] KIND_PPS   = 2'd1;
    localparam logic [1:0] KIND_CODED = 2'd2;

    // Header byte positions.
    localparam logic [3:0] CODED_START_POS = 4'd4;
    localparam logic [3:0] SPS_COUNT_POS   = 4'd10;
    localparam logic [3:0] MODE_POS        = 4'd1;
    localparam logic [3:0] STAMP_POS       = 4'd0;

    // Length field size in bytes for the configuration record.
    localparam logic [2:0] CFG_LENGTH_BYTES = 3'd2;

    // Annex B start code.
    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
    localparam logic [1:0] START_CODE_LAST = 2'd3;

    // One input byte with its message context.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] stamp;
    } item_t;

    // One run of results caused by a single input byte: either the four
    // start code bytes or a single unit data byte.
    typedef struct packed {
        logic        is_start;
        logic [7:0]  data;
        logic [1:0]  kind;
        logic        unit_end;
        logic        trunc;
        logic [31:0] stamp;
    } run_t;

endpackage

// ----- rtl/avc_tag_to_start_code_stream_unit.sv -----
// Top level of the AVC tag to start-code stream unit.
// Instantiates avc_ts_in_stage, avc_ts_parser and avc_ts_emit; uses avc_ts_pkg.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------------
//   input   | in_valid / in_ready   | payload_byte, last_byte, timestamp
//   output  | out_valid / out_ready | out_byte, unit_kind, frame_start,
//           |                       | frame_end, truncated, unit_timestamp,
//           |                       | last_of_run
//
// Header, length and unit data bytes are taken at one per cycle unless a byte
// with results finds the emitter busy; a byte that completes a length field
// yields four start code transactions. Bytes pass the input register and then
// the run register in the emitter; the run register sets the rate.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output holds its run while bytes without results keep flowing.
module avc_tag_to_start_code_stream_unit #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    input  logic [31:0] timestamp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  unit_kind,
    output logic        frame_start,
    output logic        frame_end,
    output logic        truncated,
    output logic [31:0] unit_timestamp,
    output logic        last_of_run
);
    import avc_ts_pkg::*;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  item_take;
    logic  run_free;
    logic  run_valid;
    run_t  run;

    assign in_item.data  = payload_byte;
    assign in_item.last  = last_byte;
    assign in_item.stamp = timestamp;

    // Input register.
    avc_ts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Parser state and run formation.
    avc_ts_parser #(
        .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .run_free   (run_free),
        .run_valid  (run_valid),
        .run        (run)
    );

    // Result register and serializer.
    avc_ts_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .run_valid      (run_valid),
        .run            (run),
        .run_free       (run_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .unit_kind      (unit_kind),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .truncated      (truncated),
        .unit_timestamp (unit_timestamp),
        .last_of_run    (last_of_run)
    );

endmodule

// ----- rtl/avc_ts_in_stage.sv -----
// Input register for the AVC tag to start-code stream unit.
// Holds one accepted byte until the parser takes it; depends on avc_ts_pkg.
module avc_ts_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  avc_ts_pkg::item_t    in_item,
    output logic                 item_valid,
    output avc_ts_pkg::item_t    item,
    input  logic                 item_take
);
    import avc_ts_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register may be refilled in the same cycle it is drained.
    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/avc_ts_parser.sv -----
// Message parser for the AVC tag to start-code stream unit.
// Walks the header, length fields and unit bodies one byte per cycle unless
// the emitter stalls it; each byte's results form one run; uses avc_ts_pkg.
module avc_ts_parser #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  avc_ts_pkg::item_t    item,
    output logic                 item_take,
    input  logic                 run_free,
    output logic                 run_valid,
    output avc_ts_pkg::run_t     run
);
    import avc_ts_pkg::*;

    localparam int ACC_W = (8 * LENGTH_FIELD_BYTES > 16) ? 8 * LENGTH_FIELD_BYTES : 16;
    localparam logic [2:0] CODED_LENGTH_BYTES = 3'(LENGTH_FIELD_BYTES);

    phase_t           phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic             cfg_mode_reg, cfg_mode_next;
    logic [4:0]       sets_left_reg, sets_left_next;
    logic             in_pps_reg, in_pps_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]       seen_reg, seen_next;
    logic [31:0]      data_left_reg, data_left_next;
    logic [31:0]      stamp_reg, stamp_next;

    logic             produce;
    logic             advance;
    logic [1:0]       kind;
    logic [2:0]       need;
    logic [ACC_W-1:0] acc_shift;
    logic [4:0]       sets_dec;
    phase_t           finish_phase;
    run_t             run_c;

    // A byte that yields no result never waits for the emitter.
    assign produce   = (phase_reg == PH_DATA) ||
                       ((phase_reg == PH_LENGTH) &&
                        (({1'b0, seen_reg} + 3'd1) >= need));
    assign item_take = item_valid && (run_free || !produce);
    assign advance   = item_take;
    assign run_valid = advance && produce;
    assign run       = run_c;

    assign kind      = !cfg_mode_reg ? KIND_CODED : (in_pps_reg ? KIND_PPS : KIND_SPS);
    assign need      = cfg_mode_reg ? CFG_LENGTH_BYTES : CODED_LENGTH_BYTES;
    assign acc_shift = {acc_reg[ACC_W-9:0], item.data};
    assign sets_dec  = sets_left_reg - 5'd1;

    // Phase that follows the end of a unit.
    always_comb
    begin
        if (!cfg_mode_reg)
        begin
            finish_phase = PH_LENGTH;
        end
        else if (sets_dec != 5'd0)
        begin
            finish_phase = PH_LENGTH;
        end
        else if (!in_pps_reg)
        begin
            finish_phase = PH_PPS_COUNT;
        end
        else
        begin
            finish_phase = PH_IDLE;
        end
    end

    // Next state and run description for the byte in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cfg_mode_next  = cfg_mode_reg;
        sets_left_next = sets_left_reg;
        in_pps_next    = in_pps_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        data_left_next = data_left_reg;
        stamp_next     = stamp_reg;

        run_c.is_start = 1'b0;
        run_c.data     = item.data;
        run_c.kind     = kind;
        run_c.unit_end = 1'b0;
        run_c.trunc    = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == STAMP_POS)
                begin
                    stamp_next = item.stamp;
                end
                if (pos_reg == MODE_POS)
                begin
                    cfg_mode_next = (item.data == 8'h00);
                end
                if (!cfg_mode_next && pos_reg == CODED_START_POS)
                begin
                    phase_next = PH_LENGTH;
                end
                else if (cfg_mode_next && pos_reg == SPS_COUNT_POS)
                begin
                    sets_left_next = item.data[4:0];
                    in_pps_next    = 1'b0;
                    phase_next     = (item.data[4:0] != 5'd0) ? PH_LENGTH : PH_PPS_COUNT;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_PPS_COUNT:
            begin
                sets_left_next = item.data[4:0];
                in_pps_next    = 1'b1;
                phase_next     = (item.data[4:0] != 5'd0) ? PH_LENGTH : PH_IDLE;
            end
            PH_LENGTH:
            begin
                acc_next = acc_shift;
                if (produce)
                begin
                    data_left_next = 32'(acc_shift);
                    acc_next       = '0;
                    seen_next      = 2'd0;
                    run_c.is_start = 1'b1;
                    run_c.unit_end = (acc_shift == '0);
                    if (acc_shift == '0)
                    begin
                        phase_next = finish_phase;
                        if (cfg_mode_reg)
                        begin
                            sets_left_next = sets_dec;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    seen_next = seen_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                data_left_next = data_left_reg - 32'd1;
                run_c.unit_end = (data_left_next == 32'd0);
                if (data_left_next == 32'd0)
                begin
                    phase_next = finish_phase;
                    if (cfg_mode_reg)
                    begin
                        sets_left_next = sets_dec;
                    end
                end
            end
            default:
            begin
                // Trailing bytes after the last parameter set are ignored.
            end
        endcase

        // End of message: close an open unit as truncated, then rearm.
        if (item.last)
        begin
            if (phase_next == PH_DATA && data_left_next != 32'd0 && produce)
            begin
                run_c.unit_end = 1'b1;
                run_c.trunc    = 1'b1;
            end
            phase_next     = PH_HEADER;
            pos_next       = 4'd0;
            cfg_mode_next  = 1'b0;
            sets_left_next = 5'd0;
            in_pps_next    = 1'b0;
            acc_next       = '0;
            seen_next      = 2'd0;
            data_left_next = 32'd0;
        end

        run_c.stamp = stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 4'd0;
            cfg_mode_reg  <= 1'b0;
            sets_left_reg <= 5'd0;
            in_pps_reg    <= 1'b0;
            acc_reg       <= '0;
            seen_reg      <= 2'd0;
            data_left_reg <= 32'd0;
            stamp_reg     <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cfg_mode_reg  <= cfg_mode_next;
            sets_left_reg <= sets_left_next;
            in_pps_reg    <= in_pps_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            data_left_reg <= data_left_next;
            stamp_reg     <= stamp_next;
        end
    end

endmodule

// ----- rtl/avc_ts_emit.sv -----
// Result register and serializer for the AVC tag to start-code stream unit.
// Holds one run and presents it one output transaction at a time; depends
// on avc_ts_pkg.
module avc_ts_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 run_valid,
    input  avc_ts_pkg::run_t     run,
    output logic                 run_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic [1:0]           unit_kind,
    output logic                 frame_start,
    output logic                 frame_end,
    output logic                 truncated,
    output logic [31:0]          unit_timestamp,
    output logic                 last_of_run
);
    import avc_ts_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    run_t       run_reg;
    logic       final_elem;

    // A data run has one element; a start code run has four.
    assign final_elem = !run_reg.is_start || (idx_reg == START_CODE_LAST);
    assign run_free   = !valid_reg || (out_ready && final_elem);

    assign out_valid      = valid_reg;
    assign out_byte       = run_reg.is_start ? START_CODE[idx_reg] : run_reg.data;
    assign unit_kind      = run_reg.kind;
    assign frame_start    = run_reg.is_start && (idx_reg == 2'd0);
    assign frame_end      = final_elem && run_reg.unit_end;
    assign truncated      = final_elem && run_reg.trunc;
    assign unit_timestamp = run_reg.stamp;
    assign last_of_run    = final_elem;

    // Element counter and occupancy.
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (run_free)
        begin
            valid_next = run_valid;
            idx_next   = 2'd0;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_free && run_valid)
        begin
            run_reg <= run;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for avc_tag_to_start_code_stream_unit.
// Feeds video tag messages byte by byte and compares the start-code stream against
// an in-bench behavioral parser. Depends on rtl/avc_ts_pkg.sv and the unit's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import avc_ts_pkg::*;

    localparam int LEN_FIELD_BYTES = 4;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_BYTES    = 140;
    localparam int MAX_REPORTS     = 10;

    // One emitted stream byte with its side-band flags.
    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic        fs;
        logic        fe;
        logic        tr;
        logic [31:0] stamp;
        logic        lor;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] timestamp;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [1:0]  unit_kind;
    logic        frame_start;
    logic        frame_end;
    logic        truncated;
    logic [31:0] unit_timestamp;
    logic        last_of_run;

    // Parser state mirrored by the bench.
    phase_t      phase;
    logic [3:0]  hdr_pos;
    logic        cfg_mode;
    logic [4:0]  sets_left;
    logic        in_pps;
    logic [31:0] len_acc;
    logic [1:0]  len_seen;
    logic [31:0] data_left;
    logic [31:0] held_stamp;

    stream_byte_t annexb_queue[$];
    logic [7:0]   msg[$];

    int  error_count = 0;
    int  bytes_sent = 0;
    int  msgs_sent = 0;
    int  results_seen = 0;
    int  trunc_seen = 0;
    bit  quiet = 1'b0;

    avc_tag_to_start_code_stream_unit #(
        .LENGTH_FIELD_BYTES(LEN_FIELD_BYTES)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .payload_byte   (payload_byte),
        .last_byte      (last_byte),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .unit_kind      (unit_kind),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .truncated      (truncated),
        .unit_timestamp (unit_timestamp),
        .last_of_run    (last_of_run)
    );

    // Clock generation, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random idle length: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Load a set count and pick the next phase.
    function automatic void open_sets(input logic [7:0] b, input logic pictures);
        sets_left = b[4:0];
        in_pps = pictures;
        if (sets_left != 5'd0)
            phase = PH_LENGTH;
        else
            phase = pictures ? PH_IDLE : PH_PPS_COUNT;
    endfunction

    // A unit has been fully emitted; move to the next length field or set.
    function automatic void close_unit();
        if (!cfg_mode)
        begin
            phase = PH_LENGTH;
            return;
        end
        sets_left = sets_left - 5'd1;
        if (sets_left != 5'd0)
            phase = PH_LENGTH;
        else if (!in_pps)
            phase = PH_PPS_COUNT;
        else
            phase = PH_IDLE;
    endfunction

    // Work out the stream bytes caused by one accepted input byte.
    task automatic convert_byte(input logic [7:0] b, input logic lst, input logic [31:0] st);
        stream_byte_t res[4];
        int           n;
        int           i;
        int           need;
        logic [1:0]   kind;
        n = 0;
        kind = cfg_mode ? (in_pps ? KIND_PPS : KIND_SPS) : KIND_CODED;
        case (phase)
            PH_HEADER:
            begin
                if (hdr_pos == STAMP_POS)
                    held_stamp = st;
                if (hdr_pos == MODE_POS)
                    cfg_mode = (b == 8'h00);
                if (!cfg_mode && hdr_pos == CODED_START_POS)
                    phase = PH_LENGTH;
                else if (cfg_mode && hdr_pos == SPS_COUNT_POS)
                    open_sets(b, 1'b0);
                else
                    hdr_pos = hdr_pos + 4'd1;
            end
            PH_PPS_COUNT:
                open_sets(b, 1'b1);
            PH_LENGTH:
            begin
                need = cfg_mode ? int'(CFG_LENGTH_BYTES) : LEN_FIELD_BYTES;
                len_acc = {len_acc[23:0], b};
                if (int'(len_seen) + 1 >= need)
                begin
                    data_left = len_acc;
                    len_acc = '0;
                    len_seen = '0;
                    for (i = 0; i < 4; i++)
                        res[i] = '{START_CODE[i], kind, (i == 0), (i == 3 && data_left == 0),
                                   1'b0, held_stamp, 1'b0};
                    n = 4;
                    if (data_left == 0)
                        close_unit();
                    else
                        phase = PH_DATA;
                end
                else
                begin
                    len_seen = len_seen + 2'd1;
                end
            end
            PH_DATA:
            begin
                data_left = data_left - 32'd1;
                res[0] = '{b, kind, 1'b0, (data_left == 0), 1'b0, held_stamp, 1'b0};
                n = 1;
                if (data_left == 0)
                    close_unit();
            end
            default:
            begin
            end
        endcase
        // End of message: close an open unit early and rearm the header parser.
        if (lst)
        begin
            if (phase == PH_DATA && data_left != 0 && n > 0)
            begin
                res[n-1].fe = 1'b1;
                res[n-1].tr = 1'b1;
            end
            phase = PH_HEADER;
            hdr_pos = '0;
            cfg_mode = 1'b0;
            sets_left = '0;
            in_pps = 1'b0;
            len_acc = '0;
            len_seen = '0;
            data_left = '0;
        end
        if (n > 0)
            res[n-1].lor = 1'b1;
        for (i = 0; i < n; i++)
            annexb_queue.push_back(res[i]);
    endtask

    // Send one byte as an input transaction and predict its results.
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] st);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        payload_byte = b;
        last_byte = lst;
        timestamp = st;
        do
            @(posedge clk);
        while (!in_ready);
        convert_byte(b, lst, st);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send the built message; later bytes carry stray stamps to check latching.
    task automatic send_msg(input logic [31:0] st);
        int i;
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], (i == msg.size() - 1), (i == 0) ? st : $urandom());
        msg.delete();
        msgs_sent++;
    endtask

    // Hold the input off until every predicted byte has come out.
    task automatic drain_stream();
        in_valid = 1'b0;
        while (annexb_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic log_error(input string text);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, text);
    endtask

    // Coded units, including one of zero length, ending on a length field.
    task automatic test_coded_units();
        msg = '{8'h17, 8'h01, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55,
                8'h00, 8'h00, 8'h00, 8'h00};
        send_msg(32'hFFFF_FFFF);
        drain_stream();
    endtask

    // Configuration record with one SPS, one PPS and a trailing ignored byte.
    task automatic test_config_record();
        msg = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF, 8'hE1,
                8'h00, 8'h01, 8'h67,
                8'h01, 8'h00, 8'h01, 8'h68,
                8'h00};
        send_msg(32'h0000_0000);
        drain_stream();
    endtask

    // Zero SPS and zero PPS counts; the rest of the message is ignored.
    task automatic test_empty_sets();
        msg = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h42, 8'hC0, 8'h1E, 8'hFF, 8'hE0,
                8'h00, 8'h5A};
        send_msg(32'h5A5A_A5A5);
        drain_stream();
    endtask

    // Messages that end inside a unit, a length field and a header.
    task automatic test_early_end();
        msg = '{8'h27, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3C, 8'hC3};
        send_msg(32'hA5A5_5A5A);
        msg = '{8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34};
        send_msg(32'h1234_5678);
        msg = '{8'h17, 8'h00, 8'h00};
        send_msg(32'h8765_4321);
        drain_stream();
    endtask

    // Random messages: mostly well-formed, some cut short, some pure noise.
    task automatic test_random_messages();
        int          target;
        int          r;
        int          k;
        int          j;
        int          units;
        int          cut;
        logic [31:0] len;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            r = $urandom_range(99);
            quiet = ($urandom_range(5) == 0);
            if (r < 45)
            begin
                // Coded mode: header, then length-prefixed units.
                msg.push_back(8'($urandom()));
                msg.push_back(8'($urandom_range(255, 1)));
                repeat (3) msg.push_back(8'($urandom()));
                units = $urandom_range(3, 1);
                for (k = 0; k < units; k++)
                begin
                    if ($urandom_range(7) == 0)
                    begin
                        len = $urandom();
                        for (j = 3; j >= 0; j--)
                            msg.push_back(len[8*j +: 8]);
                        repeat ($urandom_range(3)) msg.push_back(8'($urandom()));
                        break;
                    end
                    len = $urandom_range(6);
                    for (j = 3; j >= 0; j--)
                        msg.push_back(len[8*j +: 8]);
                    repeat (len) msg.push_back(8'($urandom()));
                end
            end
            else if (r < 80)
            begin
                // Configuration record with a few parameter sets of each kind.
                msg.push_back(8'($urandom()));
                msg.push_back(8'h00);
                repeat (8) msg.push_back(8'($urandom()));
                for (k = 0; k < 2; k++)
                begin
                    units = $urandom_range(3);
                    msg.push_back({3'($urandom()), 5'(units)});
                    for (j = 0; j < units; j++)
                    begin
                        len = $urandom_range(5);
                        msg.push_back(len[15:8]);
                        msg.push_back(len[7:0]);
                        repeat (len) msg.push_back(8'($urandom()));
                    end
                end
                repeat ($urandom_range(2)) msg.push_back(8'($urandom()));
            end
            else
            begin
                repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom()));
            end
            // Cut a quarter of the messages at a random byte.
            if ($urandom_range(3) == 0)
            begin
                cut = $urandom_range(msg.size() - 1);
                while (msg.size() > cut + 1)
                    void'(msg.pop_back());
            end
            send_msg($urandom());
            if ($urandom_range(7) == 0)
                drain_stream();
        end
        quiet = 1'b0;
        drain_stream();
    endtask

    // Output side: check each accepted transaction, then pick the next ready.
    initial
    begin
        stream_byte_t got;
        stream_byte_t want;
        int           stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid && out_ready)
            begin
                got = '{out_byte, unit_kind, frame_start, frame_end, truncated,
                        unit_timestamp, last_of_run};
                results_seen++;
                if (got.tr === 1'b1)
                    trunc_seen++;
                if (annexb_queue.size() == 0)
                begin
                    log_error($sformatf("unexpected byte %02h kind %0d", got.data, got.kind));
                end
                else
                begin
                    want = annexb_queue.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.fs !== want.fs || got.fe !== want.fe || got.tr !== want.tr ||
                        got.stamp !== want.stamp || got.lor !== want.lor)
                        log_error($sformatf({"exp byte %02h kind %0d fs %0b fe %0b tr %0b ",
                            "ts %08h lor %0b, got byte %02h kind %0d fs %0b fe %0b tr %0b ",
                            "ts %08h lor %0b"},
                            want.data, want.kind, want.fs, want.fe, want.tr, want.stamp,
                            want.lor, got.data, got.kind, got.fs, got.fe, got.tr, got.stamp,
                            got.lor));
                end
            end
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed tests, random traffic, final report.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        payload_byte = '0;
        last_byte = 1'b0;
        timestamp = '0;
        phase = PH_HEADER;
        hdr_pos = '0;
        cfg_mode = 1'b0;
        sets_left = '0;
        in_pps = 1'b0;
        len_acc = '0;
        len_seen = '0;
        data_left = '0;
        held_stamp = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_coded_units();
        test_config_record();
        test_empty_sets();
        test_early_end();
        test_random_messages();

        drain_stream();
        repeat (10) @(negedge clk);
        $display("Sent %0d messages (%0d bytes); checked %0d stream bytes, %0d truncated.",
                 msgs_sent, bytes_sent, results_seen, trunc_seen);
        $display("Errors: %0d", error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
